// File: src/mss_pkg.sv
// Shared types, codes and helpers for the motor soft start/stop sequencer.
package mss_pkg;

   // Width of the ramp and idle countdown timers; the ramp timer also times the wake delay.
   localparam int TIMER_WIDTH = 16;
   localparam logic [31:0] TIMER_MAX32 = 32'((64'd1 << TIMER_WIDTH) - 64'd1);

   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 16;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_WAKE_DELAY    = 3'd0,
      CSR_RAMP_INTERVAL = 3'd1,
      CSR_STANDBY_DELAY = 3'd2,
      CSR_SPEED_STEP    = 3'd3,
      CSR_TOP_SPEED     = 3'd4,
      CSR_INITIAL_SPEED = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      REQ_TICK  = 2'd0,
      REQ_START = 2'd1,
      REQ_STOP  = 2'd2
   } req_code_type;

   typedef enum logic [2:0] {
      MODE_STANDBY   = 3'd0,
      MODE_AWAKENING = 3'd1,
      MODE_STOPPED   = 3'd2,
      MODE_RUNNING   = 3'd3,
      MODE_STOPPING  = 3'd4
   } mode_type;

   typedef struct packed {
      logic [1:0] req_type;
      logic       direction;
      logic       battery_low;
   } req_word_type;

   typedef struct packed {
      logic [7:0] pwm_duty;
      logic       direction_out;
      logic       relay_on;
      logic [2:0] motor_mode;
      logic       is_running;
      logic       is_stopped;
   } rsp_word_type;

   // Load value for a timer: saturate a delay that does not fit.
   function automatic logic [TIMER_WIDTH-1:0] timer_load(input logic [15:0] delay);
      logic [31:0] d32;
      d32 = {16'd0, delay};
      if (d32 > TIMER_MAX32) begin
         return TIMER_MAX32[TIMER_WIDTH-1:0];
      end
      return d32[TIMER_WIDTH-1:0];
   endfunction

endpackage

// File: src/motor_soft_start_stop_sequencer.sv
// Top level of the motor soft start/stop sequencer: state update and result register.
//
//   channel | direction | handshake             | word
//   req_    | in        | req_valid / req_stall | req_word_type (type, direction, battery)
//   rsp_    | out       | rsp_valid / rsp_stall | rsp_word_type (duty, dir, relay, mode)
//   csr_    | in        | csr_write_en          | csr_index, csr_write_data
//
// One word per cycle unless the result is stalled. A request word updates the mode,
// speed and timer registers in the cycle it is accepted; its result word appears in
// the result register in the next cycle. The single result register sets the rate:
// a new word is taken whenever that register is empty or being drained in the same cycle.
// Reset (synchronous) loads the default settings, puts the sequencer in standby with
// the relay off and both timers idle, and empties the result register.
// A stalled result holds the register and stalls the request side.
module motor_soft_start_stop_sequencer
   import mss_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,

   input  logic                       req_valid,
   output logic                       req_stall,
   input  req_word_type               req_word,

   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output rsp_word_type               rsp_word,

   input  logic                       csr_write_en,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_write_data
);

   // Settings registers
   logic [15:0] wake_delay_ff,    wake_delay_in;
   logic [15:0] ramp_interval_ff, ramp_interval_in;
   logic [15:0] standby_delay_ff, standby_delay_in;
   logic [7:0]  speed_step_ff,    speed_step_in;
   logic [7:0]  top_speed_ff,     top_speed_in;
   logic [7:0]  initial_speed_ff, initial_speed_in;

   // Sequencer state
   mode_type               mode_ff,        mode_in;
   logic [7:0]             speed_ff,       speed_in;
   logic                   pend_dir_ff,    pend_dir_in;
   logic                   drive_dir_ff,   drive_dir_in;
   logic                   relay_ff,       relay_in;
   logic [TIMER_WIDTH-1:0] ramp_left_ff,   ramp_left_in;
   logic                   ramp_active_ff, ramp_active_in;
   logic [TIMER_WIDTH-1:0] idle_left_ff,   idle_left_in;
   logic                   idle_active_ff, idle_active_in;

   // Result register
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_word_ff,  rsp_word_in;

   logic req_accept;

   // Take a new word unless a finished result is held back.
   assign req_stall  = rsp_valid_ff & rsp_stall;
   assign req_accept = req_valid & ~req_stall;

   // ---------------------------------------------------------------------------
   // Settings writes: drop writes to unknown indexes.
   // ---------------------------------------------------------------------------
   always_comb begin
      wake_delay_in    = wake_delay_ff;
      ramp_interval_in = ramp_interval_ff;
      standby_delay_in = standby_delay_ff;
      speed_step_in    = speed_step_ff;
      top_speed_in     = top_speed_ff;
      initial_speed_in = initial_speed_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_WAKE_DELAY:    wake_delay_in    = csr_write_data;
            CSR_RAMP_INTERVAL: ramp_interval_in = csr_write_data;
            CSR_STANDBY_DELAY: standby_delay_in = csr_write_data;
            CSR_SPEED_STEP:    speed_step_in    = csr_write_data[7:0];
            CSR_TOP_SPEED:     top_speed_in     = csr_write_data[7:0];
            CSR_INITIAL_SPEED: initial_speed_in = csr_write_data[7:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------------
   // Next state. A tick counts the timers down and then runs the update rule;
   // a start or stop runs the update rule and then applies the command.
   // ---------------------------------------------------------------------------
   always_comb begin
      logic       ramp_done;
      logic       idle_done;
      logic       run_rule;
      logic [8:0] speed_up;

      mode_in        = mode_ff;
      speed_in       = speed_ff;
      pend_dir_in    = pend_dir_ff;
      drive_dir_in   = drive_dir_ff;
      relay_in       = relay_ff;
      ramp_left_in   = ramp_left_ff;
      ramp_active_in = ramp_active_ff;
      idle_left_in   = idle_left_ff;
      idle_active_in = idle_active_ff;
      run_rule       = 1'b0;

      if (req_accept) begin
         unique case (req_word.req_type)
            REQ_TICK: begin
               // Count running timers down, holding at zero.
               if (ramp_active_ff && ramp_left_ff != '0) begin
                  ramp_left_in = ramp_left_ff - 1'b1;
               end
               if (idle_active_ff && idle_left_ff != '0) begin
                  idle_left_in = idle_left_ff - 1'b1;
               end
               run_rule = 1'b1;
            end
            REQ_START, REQ_STOP: run_rule = 1'b1;
            default: ;
         endcase
      end

      ramp_done = ramp_active_in && ramp_left_in == '0;
      idle_done = idle_active_in && idle_left_in == '0;
      speed_up  = {1'b0, speed_ff} + {1'b0, speed_step_ff};

      // Update rule
      if (run_rule) begin
         unique case (mode_ff)
            MODE_AWAKENING: begin
               if (ramp_done) begin
                  // Relay has settled: launch the motor.
                  idle_active_in = 1'b0;
                  idle_left_in   = '0;
                  mode_in        = MODE_RUNNING;
                  drive_dir_in   = pend_dir_ff;
                  speed_in       = initial_speed_ff;
                  ramp_left_in   = timer_load(ramp_interval_ff);
                  ramp_active_in = 1'b1;
               end
            end
            MODE_STOPPED: begin
               if (idle_done) begin
                  relay_in = 1'b0;
                  mode_in  = MODE_STANDBY;
               end
            end
            MODE_RUNNING: begin
               if (ramp_done) begin
                  speed_in = (speed_up > {1'b0, top_speed_ff}) ? top_speed_ff
                                                               : speed_up[7:0];
                  ramp_left_in   = timer_load(ramp_interval_ff);
                  ramp_active_in = 1'b1;
               end
            end
            MODE_STOPPING: begin
               if (ramp_done) begin
                  if (speed_ff >= speed_step_ff) begin
                     speed_in       = speed_ff - speed_step_ff;
                     ramp_left_in   = timer_load(ramp_interval_ff);
                     ramp_active_in = 1'b1;
                  end else begin
                     speed_in       = '0;
                     mode_in        = MODE_STOPPED;
                     idle_left_in   = timer_load(standby_delay_ff);
                     idle_active_in = 1'b1;
                  end
               end
            end
            default: ;
         endcase
      end

      // Commands, applied to the state the update rule left.
      if (req_accept && req_word.req_type == REQ_START && !req_word.battery_low) begin
         unique case (mode_in)
            MODE_STANDBY: begin
               mode_in        = MODE_AWAKENING;
               pend_dir_in    = req_word.direction;
               relay_in       = 1'b1;
               ramp_left_in   = timer_load(wake_delay_ff);
               ramp_active_in = 1'b1;
            end
            MODE_AWAKENING: pend_dir_in = req_word.direction;
            MODE_STOPPED: begin
               pend_dir_in    = req_word.direction;
               idle_active_in = 1'b0;
               idle_left_in   = '0;
               mode_in        = MODE_RUNNING;
               drive_dir_in   = req_word.direction;
               speed_in       = initial_speed_ff;
               ramp_left_in   = timer_load(ramp_interval_ff);
               ramp_active_in = 1'b1;
            end
            default: ;
         endcase
      end

      if (req_accept && req_word.req_type == REQ_STOP) begin
         if (mode_in == MODE_AWAKENING || mode_in == MODE_RUNNING) begin
            mode_in        = MODE_STOPPING;
            speed_in       = (speed_in >= speed_step_ff) ? speed_in - speed_step_ff : '0;
            ramp_left_in   = timer_load(ramp_interval_ff);
            ramp_active_in = 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Result word: the state after the accepted word.
   // ---------------------------------------------------------------------------
   always_comb begin
      rsp_word_in.pwm_duty      = speed_in;
      rsp_word_in.direction_out = drive_dir_in;
      rsp_word_in.relay_on      = relay_in;
      rsp_word_in.motor_mode    = mode_in;
      rsp_word_in.is_running    = (mode_in == MODE_RUNNING || mode_in == MODE_AWAKENING);
      rsp_word_in.is_stopped    = (mode_in == MODE_STOPPED || mode_in == MODE_STANDBY);

      // Load on accept, drop once taken, otherwise hold.
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wake_delay_ff    <= 16'd100;
         ramp_interval_ff <= 16'd50;
         standby_delay_ff <= 16'd10000;
         speed_step_ff    <= 8'd8;
         top_speed_ff     <= 8'd255;
         initial_speed_ff <= 8'd64;
         mode_ff          <= MODE_STANDBY;
         speed_ff         <= '0;
         pend_dir_ff      <= 1'b0;
         drive_dir_ff     <= 1'b0;
         relay_ff         <= 1'b0;
         ramp_left_ff     <= '0;
         ramp_active_ff   <= 1'b0;
         idle_left_ff     <= '0;
         idle_active_ff   <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         wake_delay_ff    <= wake_delay_in;
         ramp_interval_ff <= ramp_interval_in;
         standby_delay_ff <= standby_delay_in;
         speed_step_ff    <= speed_step_in;
         top_speed_ff     <= top_speed_in;
         initial_speed_ff <= initial_speed_in;
         mode_ff          <= mode_in;
         speed_ff         <= speed_in;
         pend_dir_ff      <= pend_dir_in;
         drive_dir_ff     <= drive_dir_in;
         relay_ff         <= relay_in;
         ramp_left_ff     <= ramp_left_in;
         ramp_active_ff   <= ramp_active_in;
         idle_left_ff     <= idle_left_in;
         idle_active_ff   <= idle_active_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   // Payload register: no reset needed.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // ---------------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------------
   // An accepted word always shows up in the result register next cycle.
   a_accept_gives_result : assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_valid_ff)
      else $error("accepted word produced no result");

   // The relay is only off in standby.
   a_relay_off_standby : assert property (@(posedge clock) disable iff (reset)
      !relay_ff |-> mode_ff == MODE_STANDBY)
      else $error("relay off outside standby");

   // No duty while the motor is stopped or in standby.
   a_idle_zero_duty : assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_STOPPED || mode_ff == MODE_STANDBY) |-> speed_ff == '0)
      else $error("nonzero duty while stopped");

   // A held result does not change.
   a_held_result : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> rsp_valid_ff && $stable(rsp_word_ff))
      else $error("held result changed");

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the motor soft start/stop sequencer.
module tb_top;
   import mss_pkg::*;

   // Request code that the sequencer must treat as a no-op.
   localparam logic [1:0] REQ_UNUSED     = 2'd3;
   // Register indexes past the last register; writes there must be dropped.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_NONE_LO = 3'd6;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_NONE_HI = 3'd7;
   localparam int   STALL_LIMIT    = 5000;
   localparam int   MAX_REPORTS    = 10;

   logic         clock = 1'b0;
   logic         reset = 1'b1;

   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_word = '0;

   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_word;

   logic                       csr_write_en   = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index      = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_write_data = '0;

   motor_soft_start_stop_sequencer DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_word       (req_word),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_word       (rsp_word),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   always #1 clock = ~clock;

   // Request words waiting for the driver, and status words the sequencer owes us.
   req_word_type pending_req_q[$];
   rsp_word_type expected_status_q[$];

   // Idle percentages per side; the stimulus thread changes them between phases.
   int unsigned send_gap_pct   = 36;
   int unsigned recv_stall_pct = 67;

   // Set at the rising edge that takes a request word, consumed at the next falling edge.
   bit req_taken = 1'b0;

   int mismatch_count = 0;
   int results_seen   = 0;
   int csr_writes     = 0;
   int quiet_cycles   = 0;
   int kind_count[4];
   logic [4:0] modes_seen = '0;

   // ------------------------------------------------------------------
   // Shadow copy of the settings registers, as the sequencer should hold them.
   // ------------------------------------------------------------------
   logic [15:0] cfg_wake_delay;
   logic [15:0] cfg_ramp_interval;
   logic [15:0] cfg_standby_delay;
   logic [7:0]  cfg_speed_step;
   logic [7:0]  cfg_top_speed;
   logic [7:0]  cfg_initial_speed;

   // ------------------------------------------------------------------
   // Shadow copy of the sequencer state.
   // ------------------------------------------------------------------
   mode_type               seq_mode;
   logic [7:0]             seq_speed;
   logic                   seq_pending_dir;
   logic                   seq_driven_dir;
   logic                   seq_relay;
   logic [TIMER_WIDTH-1:0] ramp_left;
   logic                   ramp_armed;
   logic [TIMER_WIDTH-1:0] idle_left;
   logic                   idle_armed;

   // Delays are as wide as the timers here, so a load never needs to saturate.
   function automatic void arm_ramp(logic [15:0] delay);
      ramp_left  = delay;
      ramp_armed = 1'b1;
   endfunction

   // Bring the motor up from stopped: drop the idle timer, latch the direction, start ramping.
   function automatic void launch_motor();
      if (seq_mode != MODE_STOPPED) begin
         return;
      end
      idle_armed     = 1'b0;
      idle_left      = '0;
      seq_mode       = MODE_RUNNING;
      seq_driven_dir = seq_pending_dir;
      seq_speed      = cfg_initial_speed;
      arm_ramp(cfg_ramp_interval);
   endfunction

   // Per-mode reaction to an expired timer; shared by ticks and commands.
   function automatic void apply_timeouts();
      logic       ramp_done;
      logic [8:0] up;
      ramp_done = ramp_armed && (ramp_left == '0);
      case (seq_mode)
         MODE_AWAKENING: begin
            if (ramp_done) begin
               seq_mode = MODE_STOPPED;
               launch_motor();
            end
         end
         MODE_STOPPED: begin
            if (idle_armed && (idle_left == '0)) begin
               seq_relay = 1'b0;
               seq_mode  = MODE_STANDBY;
            end
         end
         MODE_RUNNING: begin
            if (ramp_done) begin
               // Cap at top speed; this also pulls an initial speed above the cap down.
               up = {1'b0, seq_speed} + {1'b0, cfg_speed_step};
               seq_speed = (up > {1'b0, cfg_top_speed}) ? cfg_top_speed : up[7:0];
               arm_ramp(cfg_ramp_interval);
            end
         end
         MODE_STOPPING: begin
            if (ramp_done) begin
               // A zero step keeps this branch true forever: the motor stays in stopping.
               if (seq_speed >= cfg_speed_step) begin
                  seq_speed = seq_speed - cfg_speed_step;
                  arm_ramp(cfg_ramp_interval);
               end else begin
                  seq_speed  = '0;
                  seq_mode   = MODE_STOPPED;
                  idle_left  = cfg_standby_delay;
                  idle_armed = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
   endfunction

   // Advance the shadow sequencer by one request word and return the status it should report.
   function automatic rsp_word_type sequencer_status_after(req_word_type w);
      rsp_word_type s;
      case (w.req_type)
         REQ_TICK: begin
            if (ramp_armed && ramp_left != '0) begin
               ramp_left = ramp_left - 1'b1;
            end
            if (idle_armed && idle_left != '0) begin
               idle_left = idle_left - 1'b1;
            end
            apply_timeouts();
         end
         REQ_START: begin
            apply_timeouts();
            // Low battery drops the command, direction included.
            if (!w.battery_low) begin
               if (seq_mode == MODE_STANDBY) begin
                  seq_mode        = MODE_AWAKENING;
                  seq_pending_dir = w.direction;
                  seq_relay       = 1'b1;
                  arm_ramp(cfg_wake_delay);
               end else if (seq_mode == MODE_AWAKENING) begin
                  seq_pending_dir = w.direction;
               end else if (seq_mode == MODE_STOPPED) begin
                  seq_pending_dir = w.direction;
                  launch_motor();
               end
            end
         end
         REQ_STOP: begin
            apply_timeouts();
            if (seq_mode == MODE_AWAKENING || seq_mode == MODE_RUNNING) begin
               seq_mode  = MODE_STOPPING;
               seq_speed = (seq_speed >= cfg_speed_step) ? seq_speed - cfg_speed_step : 8'd0;
               arm_ramp(cfg_ramp_interval);
            end
         end
         default: begin
            // Unused code: state untouched, status repeated.
         end
      endcase
      s.pwm_duty      = seq_speed;
      s.direction_out = seq_driven_dir;
      s.relay_on      = seq_relay;
      s.motor_mode    = seq_mode;
      s.is_running    = (seq_mode == MODE_RUNNING || seq_mode == MODE_AWAKENING);
      s.is_stopped    = (seq_mode == MODE_STOPPED || seq_mode == MODE_STANDBY);
      return s;
   endfunction

   // Compare one status word field by field; report the first MAX_REPORTS mismatches, count the rest.
   function automatic void check_status(rsp_word_type want, rsp_word_type got);
      if (got.pwm_duty      !== want.pwm_duty      ||
          got.direction_out !== want.direction_out ||
          got.relay_on      !== want.relay_on      ||
          got.motor_mode    !== want.motor_mode    ||
          got.is_running    !== want.is_running    ||
          got.is_stopped    !== want.is_stopped) begin
         mismatch_count++;
         if (mismatch_count <= MAX_REPORTS) begin
            $display("%0t: status %0d wrong (exp/got): duty %0d/%0d dir %b/%b relay %b/%b",
                     $realtime, results_seen,
                     want.pwm_duty, got.pwm_duty, want.direction_out, got.direction_out,
                     want.relay_on, got.relay_on);
            $display("   mode %0d/%0d run %b/%b stop %b/%b",
                     want.motor_mode, got.motor_mode,
                     want.is_running, got.is_running, want.is_stopped, got.is_stopped);
         end
      end
   endfunction

   // ------------------------------------------------------------------
   // Monitor: sample both channels and the settings port at the rising edge.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         cfg_wake_delay    = 16'd100;
         cfg_ramp_interval = 16'd50;
         cfg_standby_delay = 16'd10000;
         cfg_speed_step    = 8'd8;
         cfg_top_speed     = 8'd255;
         cfg_initial_speed = 8'd64;
         seq_mode          = MODE_STANDBY;
         seq_speed         = '0;
         seq_pending_dir   = 1'b0;
         seq_driven_dir    = 1'b0;
         seq_relay         = 1'b0;
         ramp_left         = '0;
         ramp_armed        = 1'b0;
         idle_left         = '0;
         idle_armed        = 1'b0;
         req_taken         = 1'b0;
      end else begin
         quiet_cycles++;
         // Mirror a register write; out-of-range indexes fall through untouched.
         if (csr_write_en) begin
            quiet_cycles = 0;
            case (csr_index)
               CSR_WAKE_DELAY:    cfg_wake_delay    = csr_write_data;
               CSR_RAMP_INTERVAL: cfg_ramp_interval = csr_write_data;
               CSR_STANDBY_DELAY: cfg_standby_delay = csr_write_data;
               CSR_SPEED_STEP:    cfg_speed_step    = csr_write_data[7:0];
               CSR_TOP_SPEED:     cfg_top_speed     = csr_write_data[7:0];
               CSR_INITIAL_SPEED: cfg_initial_speed = csr_write_data[7:0];
               default: begin
               end
            endcase
         end
         // Predict the status for every request word taken at this edge.
         if (req_valid && !req_stall) begin
            quiet_cycles = 0;
            req_taken    = 1'b1;
            kind_count[req_word.req_type]++;
            expected_status_q.push_back(sequencer_status_after(req_word));
            modes_seen[expected_status_q[$].motor_mode] = 1'b1;
         end
         // Check each status word against the oldest prediction.
         if (rsp_valid && !rsp_stall) begin
            quiet_cycles = 0;
            results_seen++;
            if (expected_status_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS) begin
                  $display("%0t: status word %h arrived with nothing expected",
                           $realtime, rsp_word);
               end
            end else begin
               check_status(expected_status_q.pop_front(), rsp_word);
            end
         end
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: watchdog, no word moved for %0d cycles", $realtime, STALL_LIMIT);
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------
   // Driver: change inputs at the falling edge. Hold a word until it is taken,
   // then either present the next one or idle, at the phase's gap rate.
   // The stall is drawn fresh each cycle, independent of the request side.
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_stall <= 1'b0;
      end else begin
         if (!req_valid || req_taken) begin
            if (pending_req_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
               req_word  <= pending_req_q.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
         req_taken = 1'b0;
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // Queue one request word.
   task automatic push_req(logic [1:0] code, logic dir, logic low);
      req_word_type w;
      w.req_type    = code;
      w.direction   = dir;
      w.battery_low = low;
      pending_req_q.push_back(w);
   endtask

   // Queue random request words: mostly ticks so timers expire, commands in between,
   // a few unused codes and a share of low-battery starts.
   task automatic push_random(int count);
      int unsigned pick;
      logic [1:0]  code;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(99);
         if (pick < 58) begin
            code = REQ_TICK;
         end else if (pick < 75) begin
            code = REQ_START;
         end else if (pick < 94) begin
            code = REQ_STOP;
         end else begin
            code = REQ_UNUSED;
         end
         push_req(code, 1'($urandom_range(1)), $urandom_range(99) < 20);
      end
   endtask

   // Wait until every queued word has gone in and every status word has come back,
   // then let the pipeline settle. Look at the queues at the rising edge, where the
   // driver's outputs have settled.
   task automatic drain();
      while (pending_req_q.size() != 0 || req_valid || expected_status_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (4) @(negedge clock);
   endtask

   // Write one settings register; only called while the sequencer is idle.
   task automatic write_csr(logic [CSR_INDEX_WIDTH-1:0] idx, logic [CSR_DATA_WIDTH-1:0] data);
      @(negedge clock);
      csr_write_en   <= 1'b1;
      csr_index      <= idx;
      csr_write_data <= data;
      @(negedge clock);
      csr_write_en   <= 1'b0;
      csr_writes++;
   endtask

   task automatic load_settings(logic [15:0] wake, logic [15:0] ramp, logic [15:0] standby,
                                logic [15:0] step, logic [15:0] top, logic [15:0] init_speed);
      write_csr(CSR_WAKE_DELAY, wake);
      write_csr(CSR_RAMP_INTERVAL, ramp);
      write_csr(CSR_STANDBY_DELAY, standby);
      write_csr(CSR_SPEED_STEP, step);
      write_csr(CSR_TOP_SPEED, top);
      write_csr(CSR_INITIAL_SPEED, init_speed);
   endtask

   // ------------------------------------------------------------------
   // Stimulus thread: reset, then phases of settings and request words.
   // ------------------------------------------------------------------
   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Phase 1: short delays so a full start, ramp, stop and power-down fits in a
      // couple dozen words. Upper data bits on the 8-bit registers must be dropped.
      load_settings(16'd2, 16'd1, 16'd3, 16'hFF64, 16'hAAC8, 16'd150);
      push_req(REQ_START,  1'b1, 1'b1);   // low battery: start ignored
      push_req(REQ_STOP,   1'b0, 1'b0);   // stop in standby: ignored
      push_req(REQ_UNUSED, 1'b1, 1'b1);   // unused code: no change
      push_req(REQ_START,  1'b1, 1'b0);   // relay on, awakening
      push_req(REQ_START,  1'b0, 1'b0);   // start while awakening: replace direction
      push_req(REQ_TICK,   1'b0, 1'b0);
      push_req(REQ_TICK,   1'b1, 1'b1);   // wake delay done: running at initial speed
      push_req(REQ_START,  1'b1, 1'b0);   // start while running: ignored
      push_req(REQ_TICK,   1'b0, 1'b0);   // step up, clipped at top speed
      push_req(REQ_TICK,   1'b0, 1'b0);
      push_req(REQ_STOP,   1'b1, 1'b0);   // begin ramp down
      push_req(REQ_START,  1'b0, 1'b0);   // start while stopping: ignored
      push_req(REQ_STOP,   1'b0, 1'b1);   // stop while stopping: ignored
      push_req(REQ_TICK,   1'b0, 1'b0);
      push_req(REQ_TICK,   1'b0, 1'b0);   // duty below one step: stopped, idle timer armed
      push_req(REQ_STOP,   1'b0, 1'b0);   // stop while stopped: ignored
      push_req(REQ_START,  1'b1, 1'b1);   // low battery in stopped: ignored
      push_req(REQ_START,  1'b1, 1'b0);   // restart straight from stopped
      push_req(REQ_STOP,   1'b0, 1'b0);
      push_req(REQ_TICK,   1'b0, 1'b0);
      push_req(REQ_TICK,   1'b0, 1'b0);
      push_req(REQ_TICK,   1'b0, 1'b0);
      push_req(REQ_TICK,   1'b0, 1'b0);   // idle time out: relay off, standby
      push_req(REQ_TICK,   1'b1, 1'b1);
      push_random(260);
      drain();

      // Phase 2: zero delays and the widest step, initial speed above a zero cap.
      load_settings(16'd0, 16'd0, 16'd0, 16'd255, 16'd0, 16'd255);
      push_random(130);
      drain();

      // Phase 3: swap the idle pattern. Longest delays and a zero step, so the
      // ramps freeze; stray writes to unused indexes must change nothing.
      send_gap_pct   = 67;
      recv_stall_pct = 36;
      load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'd255, 16'd0);
      write_csr(CSR_NONE_LO, 16'd1);
      write_csr(CSR_NONE_HI, 16'h0000);
      push_random(40);
      drain();

      // Phase 4: random short delays and random speeds; hold the sender once midway
      // until every status word is back.
      load_settings(16'($urandom_range(1, 4)), 16'($urandom_range(1, 3)),
                    16'($urandom_range(1, 8)), 16'($urandom_range(1, 255)),
                    16'($urandom_range(255)), 16'($urandom_range(255)));
      push_random(130);
      drain();
      push_random(130);
      drain();

      // Phase 5: no idling on either side, new random settings.
      send_gap_pct   = 0;
      recv_stall_pct = 0;
      load_settings(16'($urandom_range(1, 4)), 16'($urandom_range(1, 3)),
                    16'($urandom_range(1, 8)), 16'($urandom_range(1, 255)),
                    16'($urandom_range(255)), 16'($urandom_range(255)));
      push_random(130);
      drain();
      repeat (8) @(negedge clock);

      if (expected_status_q.size() != 0) begin
         mismatch_count++;
         $display("%0d status words never arrived", expected_status_q.size());
      end
      $display("sent %0d ticks, %0d starts, %0d stops, %0d unused codes; %0d csr writes",
               kind_count[0], kind_count[1], kind_count[2], kind_count[3], csr_writes);
      $display("checked %0d status words, modes reached %b (bit per mode), %0d mismatches",
               results_seen, modes_seen, mismatch_count);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
